// ===== rtl/core/htbl_pkg.sv =====
`default_nettype none

package htbl_pkg;

    localparam int TIME_W    = 48;
    localparam int VAL_W     = 32;
    localparam int P_W       = 42;
    localparam int HALF_W    = 21;
    localparam int PROD_W    = HALF_W + VAL_W;
    localparam int X_W       = P_W + VAL_W;
    localparam int US_PER_MS = 1000;
    localparam int PERIOD_RST = 1000;

    typedef struct packed {
        logic [0:0]        func;
        logic [4:0]        slot;
        logic [TIME_W-1:0] now_us;
        logic [VAL_W-1:0]  amount;
        logic [VAL_W-1:0]  rate;
        logic [VAL_W-1:0]  period_ms;
    } htbl_in_t;

    typedef struct packed {
        logic [VAL_W-1:0] granted;
        logic [VAL_W-1:0] tokens_left;
    } htbl_out_t;

    localparam logic [0:0] FUNC_REQUEST = 1'b0;
    localparam logic [0:0] FUNC_LOAD    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_PREP,
        ST_CHECK,
        ST_MUL_HI,
        ST_MUL_SUM,
        ST_DIV,
        ST_ADD,
        ST_FINISH
    } htbl_state_t;

    typedef struct packed {
        logic capture;
        logic oor_result;
        logic load_slot;
        logic fetch;
        logic prep;
        logic ld_full;
        logic mul_lo;
        logic mul_hi;
        logic mul_sum;
        logic div_step;
        logic ld_add;
        logic finish;
    } htbl_cmd_t;

    typedef struct packed {
        logic slot_ok;
        logic is_load;
        logic back;
        logic full;
        logic div_last;
    } htbl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/htbl_ctrl.sv =====
`default_nettype none

module htbl_ctrl
    import htbl_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire htbl_sts_t sts,
    output htbl_cmd_t      cmd
);

    htbl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;
    logic        res_load;

    assign out_free = !m_valid_reg || m_ready;
    assign res_load = cmd.oor_result || cmd.load_slot || cmd.finish;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!sts.slot_ok) begin
                    if (out_free) begin
                        cmd.oor_result = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (sts.is_load) begin
                    if (out_free) begin
                        cmd.load_slot = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.back) begin
                    state_next = ST_FINISH;
                end else if (sts.full) begin
                    cmd.ld_full = 1'b1;
                    state_next  = ST_FINISH;
                end else begin
                    cmd.mul_lo = 1'b1;
                    state_next = ST_MUL_HI;
                end
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MUL_SUM;
            end
            ST_MUL_SUM: begin
                cmd.mul_sum = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.ld_add = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/htbl_dp.sv =====
`default_nettype none

module htbl_dp
    import htbl_pkg::*;
#(
    parameter int SLOTS     = 24,
    parameter int FRAC_BITS = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire htbl_in_t  in_data,
    input  wire htbl_cmd_t cmd,
    output htbl_sts_t      sts,
    output htbl_out_t      out_data
);

    localparam int TW    = VAL_W + FRAC_BITS;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(TW + 1);

    logic [VAL_W-1:0]  slot_rate_reg   [SLOTS];
    logic [VAL_W-1:0]  slot_period_reg [SLOTS];
    logic [TW-1:0]     slot_tokens_reg [SLOTS];
    logic [TIME_W-1:0] slot_stamp_reg  [SLOTS];

    htbl_in_t          in_reg;
    htbl_out_t         out_reg;
    logic [VAL_W-1:0]  rate_reg;
    logic [VAL_W-1:0]  period_reg;
    logic [TW-1:0]     tok_reg;
    logic [TIME_W-1:0] stamp_reg;
    logic [TIME_W-1:0] p_reg;
    logic [TIME_W-1:0] e_reg;
    logic              back_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [P_W-1:0]    rem_reg;
    logic [TW-1:0]     dsh_reg;
    logic [CW-1:0]     cnt_reg;

    logic [IDX_W-1:0]  idx;
    logic [TW-1:0]     cap;
    logic [TIME_W:0]   diff;
    logic [P_W-1:0]    p_calc;
    logic [HALF_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_p;
    logic [X_W-1:0]    x_sum;
    logic [P_W:0]      trial;
    logic              ge;
    logic [P_W-1:0]    rem_next;
    logic [TW:0]       tok_sum;
    logic [TW-1:0]     tok_cl;
    logic [VAL_W-1:0]  whole;
    logic [VAL_W-1:0]  grant;
    logic [TW-1:0]     tok_new;
    logic [TW-1:0]     load_tok;

    assign idx          = IDX_W'(in_reg.slot);
    assign sts.slot_ok  = (32'(in_reg.slot) < 32'(SLOTS));
    assign sts.is_load  = (in_reg.func == FUNC_LOAD);
    assign sts.back     = back_reg;
    assign sts.full     = (e_reg >= p_reg);
    assign sts.div_last = (cnt_reg == CW'(1));

    assign cap      = TW'(rate_reg) << FRAC_BITS;
    assign load_tok = TW'(in_reg.rate) << FRAC_BITS;
    assign diff     = {1'b0, in_reg.now_us} - {1'b0, stamp_reg};
    assign p_calc   = P_W'(period_reg) * P_W'(US_PER_MS);
    assign mul_a    = cmd.mul_hi ? e_reg[2*HALF_W-1:HALF_W] : e_reg[HALF_W-1:0];
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(rate_reg);
    assign x_sum    = X_W'(acc_reg) + (X_W'(prod_reg) << HALF_W);

    assign trial    = {rem_reg, dsh_reg[TW-1]};
    assign ge       = (trial >= {1'b0, p_reg[P_W-1:0]});
    assign rem_next = ge ? P_W'(trial - {1'b0, p_reg[P_W-1:0]}) : trial[P_W-1:0];

    assign tok_sum  = (TW+1)'(tok_reg) + (TW+1)'(dsh_reg);
    assign tok_cl   = (tok_reg > cap) ? cap : tok_reg;
    assign whole    = tok_cl[TW-1:FRAC_BITS];
    assign grant    = (in_reg.amount < whole) ? in_reg.amount : whole;
    assign tok_new  = tok_cl - (TW'(grant) << FRAC_BITS);

    assign out_data = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= in_data;
        end
        if (cmd.fetch) begin
            rate_reg   <= slot_rate_reg[idx];
            period_reg <= slot_period_reg[idx];
            tok_reg    <= slot_tokens_reg[idx];
            stamp_reg  <= slot_stamp_reg[idx];
        end
        if (cmd.prep) begin
            p_reg    <= TIME_W'(p_calc);
            e_reg    <= diff[TIME_W-1:0];
            back_reg <= diff[TIME_W];
        end
        if (cmd.ld_full) begin
            tok_reg <= cap;
        end
        if (cmd.mul_lo) begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_hi) begin
            acc_reg  <= prod_reg;
            prod_reg <= mul_p;
        end
        if (cmd.mul_sum) begin
            rem_reg <= x_sum[X_W-1:VAL_W];
            dsh_reg <= TW'(x_sum[VAL_W-1:0]) << FRAC_BITS;
            cnt_reg <= CW'(TW);
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            dsh_reg <= {dsh_reg[TW-2:0], ge};
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (cmd.ld_add) begin
            tok_reg <= (tok_sum >= (TW+1)'(cap)) ? cap : tok_sum[TW-1:0];
        end
        if (cmd.oor_result) begin
            out_reg <= '0;
        end
        if (cmd.load_slot) begin
            out_reg.granted     <= '0;
            out_reg.tokens_left <= in_reg.rate;
        end
        if (cmd.finish) begin
            out_reg.granted     <= grant;
            out_reg.tokens_left <= tok_new[TW-1:FRAC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_rate_reg[i]   <= '0;
                slot_period_reg[i] <= VAL_W'(PERIOD_RST);
                slot_tokens_reg[i] <= '0;
                slot_stamp_reg[i]  <= '0;
            end
        end else if (cmd.load_slot) begin
            slot_rate_reg[idx]   <= in_reg.rate;
            slot_period_reg[idx] <= in_reg.period_ms;
            slot_tokens_reg[idx] <= load_tok;
            slot_stamp_reg[idx]  <= in_reg.now_us;
        end else if (cmd.finish) begin
            slot_tokens_reg[idx] <= tok_new;
            slot_stamp_reg[idx]  <= in_reg.now_us;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hourly_token_bucket_limiter_core.sv =====
// Channel  Handshake          Payload            Direction
// s_       s_valid / s_ready  s_data (htbl_in_t)  request or slot load in
// m_       m_valid / m_ready  m_data (htbl_out_t) grant and tokens left out
//
// One transaction in flight; s_ready is high only while the controller is idle.
// Loads and out-of-range slots are answered straight from decode. A request
// skips the multiply and divide when time ran backward or a full period
// elapsed, else it runs the one-bit-per-cycle restoring divider.
// Reset restores every slot at once; a waiting result holds the controller in
// decode for a load or out-of-range slot, and in finish for a request.
`default_nettype none

module hourly_token_bucket_limiter_core
    import htbl_pkg::*;
#(
    parameter int SLOTS     = 24,
    parameter int FRAC_BITS = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire htbl_in_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output htbl_out_t     m_data
);

    htbl_cmd_t cmd;
    htbl_sts_t sts;

    htbl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    htbl_dp #(
        .SLOTS     (SLOTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_data)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready
    ) else $error("input accepted again while a transaction is in progress");

    a_result_from_work: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready)
    ) else $error("result raised without a transaction in progress");
`endif

endmodule

`default_nettype wire

// ===== tb/htbl_grant_checker.sv =====
`timescale 1ns / 100ps

module htbl_grant_checker
    import htbl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  htbl_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  htbl_out_t m_data,
    output int        error_count,
    output int        outstanding
);

    localparam int SLOT_COUNT = 24;
    localparam int FRAC       = 16;

    logic [VAL_W-1:0]  bucket_rate   [SLOT_COUNT];
    logic [VAL_W-1:0]  bucket_period [SLOT_COUNT];
    logic [47:0]       bucket_tokens [SLOT_COUNT];
    logic [TIME_W-1:0] bucket_stamp  [SLOT_COUNT];

    htbl_out_t expected_grants[$];

    function automatic htbl_out_t serve_transaction(input htbl_in_t t);
        htbl_out_t    res;
        int           s;
        logic [47:0]  cap;
        logic [47:0]  tok;
        logic [47:0]  whole;
        logic [47:0]  grant;
        logic [63:0]  span;
        logic [63:0]  elapsed;
        logic [127:0] scaled;
        logic [127:0] refill;
        res = '0;
        s = int'(t.slot);
        if (s < SLOT_COUNT) begin
            if (t.func == FUNC_LOAD) begin
                bucket_rate[s]   = t.rate;
                bucket_period[s] = t.period_ms;
                bucket_tokens[s] = {t.rate, 16'h0000};
                bucket_stamp[s]  = t.now_us;
                res.tokens_left  = t.rate;
            end else begin
                cap  = {bucket_rate[s], 16'h0000};
                span = 64'(bucket_period[s]) * 64'(US_PER_MS);
                tok  = bucket_tokens[s];
                if (t.now_us >= bucket_stamp[s]) begin
                    elapsed = 64'(t.now_us - bucket_stamp[s]);
                    if (elapsed >= span) begin
                        tok = cap;
                    end else begin
                        scaled = (128'(elapsed) * 128'(bucket_rate[s])) << FRAC;
                        refill = scaled / 128'(span);
                        if (refill >= 128'(cap) || 128'(tok) >= 128'(cap) - refill) begin
                            tok = cap;
                        end else begin
                            tok = tok + refill[47:0];
                        end
                    end
                end
                if (tok > cap) begin
                    tok = cap;
                end
                whole = tok >> FRAC;
                grant = (48'(t.amount) < whole) ? 48'(t.amount) : whole;
                tok   = tok - (grant << FRAC);
                bucket_tokens[s] = tok;
                bucket_stamp[s]  = t.now_us;
                res.granted      = grant[VAL_W-1:0];
                res.tokens_left  = tok[47:FRAC];
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        htbl_out_t want;
        if (!aresetn) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                bucket_rate[k]   = '0;
                bucket_period[k] = VAL_W'(PERIOD_RST);
                bucket_tokens[k] = '0;
                bucket_stamp[k]  = '0;
            end
            expected_grants.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    $error("unexpected result transaction: granted %0d tokens_left %0d",
                           m_data.granted, m_data.tokens_left);
                    error_count++;
                end else begin
                    want = expected_grants.pop_front();
                    if (m_data.granted !== want.granted) begin
                        $error("granted mismatch: expected %0d, actual %0d",
                               want.granted, m_data.granted);
                        error_count++;
                    end
                    if (m_data.tokens_left !== want.tokens_left) begin
                        $error("tokens_left mismatch: expected %0d, actual %0d",
                               want.tokens_left, m_data.tokens_left);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_grants.insert(expected_grants.size(), serve_transaction(s_data));
            end
        end
        outstanding = expected_grants.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import htbl_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1950;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    htbl_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    htbl_out_t m_data;
    int        error_count;
    int        outstanding;
    int        cycle_count;
    bit        no_gaps;

    logic [TIME_W-1:0] seen_now    [32];
    logic [VAL_W-1:0]  seen_period [32];

    hourly_token_bucket_limiter_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    htbl_grant_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return VAL_W'($urandom_range(1, 16));
            3: return VAL_W'($urandom_range(1, 1000));
            4: return VAL_W'($urandom);
            default: return VAL_W'($urandom) >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic push_item(input logic [0:0] func, input logic [4:0] slot,
                             input logic [TIME_W-1:0] now, input logic [VAL_W-1:0] amount,
                             input logic [VAL_W-1:0] rate, input logic [VAL_W-1:0] period);
        htbl_in_t t;
        int       gap;
        t.func      = func;
        t.slot      = slot;
        t.now_us    = now;
        t.amount    = amount;
        t.rate      = rate;
        t.period_ms = period;
        seen_now[slot] = now;
        if (func == FUNC_LOAD) begin
            seen_period[slot] = period;
        end
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= t;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // result side: random backpressure, none while no_gaps is set
    initial begin
        int stall;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [4:0]        slot;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] span;
        logic [63:0]       draw;
        logic [VAL_W-1:0]  rate;
        logic [VAL_W-1:0]  period;
        no_gaps = 1'b0;
        for (int k = 0; k < 32; k++) begin
            seen_now[k]    = '0;
            seen_period[k] = VAL_W'(PERIOD_RST);
        end
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        push_item(FUNC_REQUEST, 0, 0, 5, 0, 0);
        push_item(FUNC_LOAD, 0, 1000, 0, 100, 10);
        push_item(FUNC_REQUEST, 0, 1000, 30, 0, 0);
        push_item(FUNC_REQUEST, 0, 3500, 0, 0, 0);
        push_item(FUNC_REQUEST, 0, 3000, 200, 0, 0);
        push_item(FUNC_REQUEST, 0, 200000, '1, 0, 0);
        push_item(FUNC_LOAD, 23, '1, '1, '1, '1);
        push_item(FUNC_REQUEST, 23, '1, '1, '1, '1);
        push_item(FUNC_REQUEST, 23, 0, '1, 0, 0);
        push_item(FUNC_LOAD, 5, 0, 0, 7, 0);
        push_item(FUNC_REQUEST, 5, 0, 3, 0, 0);
        push_item(FUNC_REQUEST, 5, 1, 10, 0, 0);
        push_item(FUNC_LOAD, 24, 77, 1, 50, 2);
        push_item(FUNC_REQUEST, 31, 77, 1, 50, 2);
        push_item(FUNC_LOAD, 1, 0, 0, '1, 1);
        push_item(FUNC_REQUEST, 1, 0, '1, 0, 0);
        push_item(FUNC_REQUEST, 1, 999, 0, 0, 0);
        push_item(FUNC_REQUEST, 1, 1000, 1, 0, 0);
        push_item(FUNC_LOAD, 2, 10, 0, 0, 5);
        push_item(FUNC_REQUEST, 2, 5000, 1, 0, 0);
        push_item(FUNC_REQUEST, 3, 12345, 1, 0, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_gaps = ((i / 150) % 4 == 3);
            slot = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                               : 5'($urandom_range(0, 23));
            if ($urandom_range(0, 99) < 12) begin
                rate   = pick_word();
                period = ($urandom_range(0, 9) < 7) ? VAL_W'($urandom_range(1, 50))
                                                    : pick_word();
                now    = seen_now[slot] + TIME_W'($urandom_range(0, 5000));
                push_item(FUNC_LOAD, slot, now, $urandom, rate, period);
            end else begin
                span = TIME_W'(seen_period[slot]) * TIME_W'(US_PER_MS);
                draw = {$urandom, $urandom};
                case ($urandom_range(0, 9))
                    0: now = seen_now[slot];
                    1, 2, 3, 4, 5: begin
                        if (span == 0) begin
                            now = seen_now[slot];
                        end else begin
                            now = seen_now[slot] + TIME_W'(draw % 64'(span));
                        end
                    end
                    6: now = seen_now[slot] + span + TIME_W'($urandom_range(0, 1000));
                    7: now = seen_now[slot] - TIME_W'($urandom_range(1, 100000));
                    default: now = draw[TIME_W-1:0];
                endcase
                push_item(FUNC_REQUEST, slot, now, pick_word(), $urandom, $urandom);
            end
        end
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (error_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
